@@ rtl/wmdd_pkg.sv @@
package wmdd_pkg;

  // Field widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int SLOPE_W      = SAMPLE_WIDTH + 1;
  localparam int FRAME_W      = 16;
  localparam int CFG_W        = 17;

  // Frame index range; the sample counter runs to twice this minus one before saturating
  localparam int MAX_FRAMES = 65536;
  localparam int IDX_W      = $clog2(2 * MAX_FRAMES);
  localparam int POS_W      = IDX_W + 1;
  localparam int CMP_W      = (IDX_W > CFG_W) ? IDX_W : CFG_W;

  localparam logic [IDX_W-1:0] N_MAX     = IDX_W'(2 * MAX_FRAMES - 1);
  localparam logic [IDX_W-1:0] FRAME_MAX = IDX_W'(MAX_FRAMES - 1);

  // Window geometry: right taps i+NEAR..i+FAR, left taps i-FAR..i-NEAR
  localparam int NEAR_OFS  = 2;
  localparam int FAR_OFS   = 7;
  localparam int WIN_DEPTH = 2 * FAR_OFS + 1;
  localparam int TAPS      = FAR_OFS - NEAR_OFS + 1;
  localparam int LEFT_LO   = FAR_OFS + NEAR_OFS;
  localparam int PAD_W     = $clog2(FAR_OFS + 1);

  // Arithmetic widths
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(TAPS);
  localparam int DIFF_W = SUM_W + 1;
  localparam int ABS_W  = DIFF_W;
  localparam int DIV_SH = ABS_W + $clog2(TAPS);
  localparam int MUL_W  = DIV_SH - 2;
  localparam int PROD_W = ABS_W + MUL_W;
  localparam int Q_W    = PROD_W - DIV_SH;

  // Reciprocal of TAPS, exact for every ABS_W-bit dividend
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((64'd1 << DIV_SH) + 64'(TAPS - 1)) / 64'(TAPS));

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic [FRAME_W-1:0]        frame_index;
    logic                      last_out;
  } out_req_t;

  typedef struct packed {
    logic                           valid;
    logic signed [SAMPLE_WIDTH-1:0] data;
  } cell_t;

  typedef struct packed {
    logic shift;
    logic clr;
    logic pad;
  } ctl_t;

  typedef struct packed {
    logic               emit;
    logic [FRAME_W-1:0] frame_index;
    logic               last;
  } job_t;

endpackage

@@ rtl/window_mean_difference_derivative_unit.sv @@
// Smoothed derivative by window mean difference. Each accepted sample enters a
// row of fifteen shift cells; for sample index i the block reports the rounded
// mean of samples i+2..i+7 minus the mean of samples i-7..i-2 (sum difference
// divided by 6, halves away from zero), clamping indices to the first and last
// sample of the set. The result for index i leaves when sample i+7 is taken,
// so results lag by seven samples. A sample with is_last set starts a flush:
// seven copies of the last sample shift into the cell row while in_stall is
// high, producing the remaining results; the set then starts over at index 0.
// Rate: one sample per cycle unless a flush or a lack of queue credit stalls.
// A result passes the job register and the arithmetic stages into the output
// queue; the eight-entry result queue and its credit count set the throughput
// when out_stall is applied. selected_frame (cfg port, reset -1) limits output
// to one index when non-negative; last_out marks a set's final result, or the
// selected match in its flush. Write cfg only while the block is idle.
module window_mean_difference_derivative_unit import wmdd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // sample requests
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_req_t                 in_req,
  // result requests
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_req_t                out_req,
  // selected_frame write
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic signed [CFG_W-1:0] cfg_data
);

  ctl_t     ctl;
  job_t     job;
  sample_t  first_sample;
  cell_t    cin [WIN_DEPTH];
  cell_t    cq  [WIN_DEPTH];
  sample_t  tap [WIN_DEPTH];
  logic     res_valid;
  out_req_t res;
  logic     pop;

  // register write is always taken
  assign cfg_ready = 1'b1;
  assign pop       = out_valid & ~out_stall;

  // Sequencer: sample counter, flush padding, selection, credit count
  wmdd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_req       (in_req),
    .in_stall     (in_stall),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .pop          (pop),
    .ctl          (ctl),
    .first_sample (first_sample),
    .job          (job)
  );

  // Head of the cell row: a new sample, or during a flush a copy of the
  // newest one, which is what clamping to the last index asks for.
  assign cin[0].valid = 1'b1;
  assign cin[0].data  = ctl.pad ? cq[0].data : in_req.sample;

  // Cell k holds the sample k positions behind the newest. Starting a new
  // set invalidates every cell behind the head; an invalid cell reads as
  // sample 0 of the set (left clamp).
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign cin[k] = cq[k-1];
    end
    wmdd_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .shift        (ctl.shift),
      .clr          (ctl.clr && (k != 0)),
      .din          (cin[k]),
      .first_sample (first_sample),
      .q            (cq[k]),
      .tap          (tap[k])
    );
  end

  // Sums, rounding and divide by 6, three stages
  wmdd_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_i     (job),
    .tap       (tap),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue; the sequencer never issues more results than it can hold
  wmdd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_req  (res),
    .pop       (pop),
    .out_valid (out_valid),
    .out_req   (out_req)
  );

endmodule

@@ rtl/wmdd_cell.sv @@
module wmdd_cell import wmdd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    shift,
  input  logic    clr,
  input  cell_t   din,
  input  sample_t first_sample,
  output cell_t   q,
  output sample_t tap
);

  logic    valid_r;
  sample_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= din.valid & ~clr;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= din.data;
    end
  end

  assign q.valid = valid_r;
  assign q.data  = data_r;

  // before sample 0 of the set: clamp to sample 0
  assign tap = valid_r ? data_r : first_sample;

endmodule

@@ rtl/wmdd_ctrl.sv @@
module wmdd_ctrl import wmdd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  in_req_t                 in_req,
  output logic                    in_stall,
  input  logic                    cfg_we,
  input  logic signed [CFG_W-1:0] cfg_data,
  input  logic                    pop,
  output ctl_t                    ctl,
  output sample_t                 first_sample,
  output job_t                    job
);

  logic signed [CFG_W-1:0] sel_r;
  sample_t                 first_r;
  logic [IDX_W-1:0]        n_r, n_nxt;
  logic [PAD_W-1:0]        pad_r, pad_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  job_t                    job_r, job_nxt;

  logic             pad_on, credit_ok, real_step, pad_step, step;
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx, idx_sat;
  logic             emit_ok, sel_all, match, emit, flush, last;

  always_comb begin
    pad_on    = (pad_r != '0);
    credit_ok = (cnt_r < CNT_W'(FIFO_DEPTH));
    in_stall  = pad_on | ~credit_ok;
    real_step = in_valid & ~in_stall;
    pad_step  = pad_on & credit_ok;
    step      = real_step | pad_step;

    // pad_r is zero outside a flush, so pos is the stream position either way
    pos     = POS_W'(n_r) + POS_W'(pad_r);
    emit_ok = (pos >= POS_W'(FAR_OFS));
    idx     = IDX_W'(pos - POS_W'(FAR_OFS));
    idx_sat = (idx > FRAME_MAX) ? FRAME_MAX : idx;

    sel_all = sel_r[CFG_W-1];
    match   = sel_all | (CMP_W'(sel_r[CFG_W-2:0]) == CMP_W'(idx));
    emit    = step & emit_ok & match;

    // with every index selected the final pad carries the end mark;
    // with one index selected the only match of a flush carries it
    flush = pad_on | in_req.is_last;
    last  = flush & (sel_all ? (pad_r == PAD_W'(FAR_OFS)) : 1'b1);

    job_nxt.emit        = emit;
    job_nxt.frame_index = FRAME_W'(idx_sat);
    job_nxt.last        = last;
  end

  always_comb begin
    n_nxt   = n_r;
    pad_nxt = pad_r;
    if (real_step) begin
      if (in_req.is_last) begin
        pad_nxt = PAD_W'(1);
      end else if (n_r != N_MAX) begin
        n_nxt = n_r + IDX_W'(1);
      end
    end else if (pad_step) begin
      if (pad_r == PAD_W'(FAR_OFS)) begin
        pad_nxt = '0;
        n_nxt   = '0;
      end else begin
        pad_nxt = pad_r + PAD_W'(1);
      end
    end
    cnt_nxt = cnt_r + CNT_W'(emit) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '1;
      n_r   <= '0;
      pad_r <= '0;
      cnt_r <= '0;
      job_r <= '0;
    end else begin
      if (cfg_we) begin
        sel_r <= cfg_data;
      end
      n_r   <= n_nxt;
      pad_r <= pad_nxt;
      cnt_r <= cnt_nxt;
      job_r <= job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (real_step && n_r == '0) begin
      first_r <= in_req.sample;
    end
  end

  assign ctl.shift    = step;
  assign ctl.clr      = real_step & (n_r == '0);
  assign ctl.pad      = pad_on;
  assign first_sample = first_r;
  assign job          = job_r;

endmodule

@@ rtl/wmdd_arith.sv @@
module wmdd_arith import wmdd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  job_t     job_i,
  input  sample_t  tap [WIN_DEPTH],
  output logic     res_valid,
  output out_req_t res
);

  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // stage 1: window sums
  sum_t rsum, lsum, rsum_r, lsum_r;
  // stage 2: rounded magnitude
  diff_t             diff;
  logic              neg;
  logic [ABS_W-1:0]  mag, x, x_r;
  logic              neg2_r;
  // stage 3: reciprocal multiply
  logic [PROD_W-1:0] prod_r;
  logic              neg3_r;
  logic [Q_W-1:0]    q;
  logic signed [Q_W:0] q_s;

  logic v1_r, v2_r, v3_r;
  job_t j1_r, j2_r, j3_r;

  always_comb begin
    rsum = '0;
    lsum = '0;
    for (int k = 0; k < TAPS; k++) begin
      rsum = rsum + sum_t'(tap[k]);
      lsum = lsum + sum_t'(tap[LEFT_LO + k]);
    end
  end

  always_comb begin
    diff = diff_t'(rsum_r) - diff_t'(lsum_r);
    neg  = diff[DIFF_W-1];
    mag  = neg ? ABS_W'(-diff) : ABS_W'(diff);
    // half of the divisor for round-half-away
    x    = mag + ABS_W'(TAPS / 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= job_i.emit;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    rsum_r <= rsum;
    lsum_r <= lsum;
    j1_r   <= job_i;
    x_r    <= x;
    neg2_r <= neg;
    j2_r   <= j1_r;
    prod_r <= PROD_W'(x_r) * PROD_W'(DIV_MUL);
    neg3_r <= neg2_r;
    j3_r   <= j2_r;
  end

  always_comb begin
    q   = prod_r[PROD_W-1:DIV_SH];
    q_s = {1'b0, q};
    res.slope       = neg3_r ? SLOPE_W'(-q_s) : SLOPE_W'(q_s);
    res.frame_index = j3_r.frame_index;
    res.last_out    = j3_r.last;
  end

  assign res_valid = v3_r;

endmodule

@@ rtl/wmdd_fifo.sv @@
module wmdd_fifo import wmdd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  out_req_t push_req,
  input  logic     pop,
  output logic     out_valid,
  output out_req_t out_req
);

  out_req_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, rd_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               head_vld_r;
  out_req_t           head_r;
  logic               take, from_mem, to_mem;

  // head register reloads whenever it is empty or being popped;
  // an empty queue passes a push straight into the head
  always_comb begin
    take     = ~head_vld_r | pop;
    from_mem = take & (cnt_r != '0);
    to_mem   = push & ~(take & (cnt_r == '0));
  end

  always_ff @(posedge clk) begin
    if (to_mem) begin
      mem[wr_r] <= push_req;
    end
    if (from_mem) begin
      head_r <= mem[rd_r];
    end else if (take && push) begin
      head_r <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r       <= '0;
      rd_r       <= '0;
      cnt_r      <= '0;
      head_vld_r <= 1'b0;
    end else begin
      if (to_mem) begin
        wr_r <= wr_r + FIFO_AW'(1);
      end
      if (from_mem) begin
        rd_r <= rd_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + CNT_W'(to_mem) - CNT_W'(from_mem);
      if (take) begin
        head_vld_r <= from_mem | push;
      end
    end
  end

  assign out_valid = head_vld_r;
  assign out_req   = head_r;

endmodule
